@@ rtl/core/hqsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hqsd_pkg
// Shared types and op codes of the quarter-scan panel driver.
// ----------------------------------------------------------------------------
package hqsd_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SWAP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0] upper_rgb;
    logic [2:0] lower_rgb;
    logic [2:0] row_address;
    logic       shift_clock;
    logic       latch_pulse;
    logic       output_enable_n;
  } out_item_t;

  localparam int unsigned DISPLAY_TICKS_RESET = 50;

endpackage

@@ rtl/core/hqsd_stream_if.sv @@
// ----------------------------------------------------------------------------
// hqsd_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface hqsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/hqsd_front.sv @@
// ----------------------------------------------------------------------------
// hqsd_front
// Accepts items, folds pixel writes into chain addresses, drops out-of-range
// writes and pushes commands into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hqsd_front #(
  parameter int PANEL_COLUMNS = 32,
  parameter int PANEL_ROWS    = 32,
  parameter int CHAIN_PANELS  = 2,
  parameter int GRID_ACROSS   = 2,
  parameter int AW            = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  hqsd_stream_if.sink         in_ch,
  output logic                q_valid,
  input  logic                q_pop,
  output logic [1:0]          q_op,
  output logic [AW-1:0]       q_addr,
  output logic [2:0]          q_rgb
);
  import hqsd_pkg::*;

  localparam int PHYS_W    = PANEL_COLUMNS * CHAIN_PANELS;
  localparam int GRID_DOWN = (CHAIN_PANELS + GRID_ACROSS - 1) / GRID_ACROSS;
  localparam int VIRT_W    = GRID_ACROSS * PANEL_COLUMNS;
  localparam int VIRT_H    = GRID_DOWN * PANEL_ROWS;
  localparam int ENT       = 2 + AW + 3;

  // pixel fold: panel index and offsets (constant divisors)
  logic [7:0]  vx, vy;
  logic [15:0] panel, px, py;
  logic        in_range;
  logic        drop;
  logic [AW-1:0] addr;

  always_comb begin
    vx = in_ch.data.pixel_x;
    vy = in_ch.data.pixel_y;
    panel = 16'((int'(vy) / PANEL_ROWS) * GRID_ACROSS + int'(vx) / PANEL_COLUMNS);
    px    = 16'(int'(panel) * PANEL_COLUMNS + int'(vx) % PANEL_COLUMNS);
    py    = 16'(int'(vy) % PANEL_ROWS);
    in_range = (int'(vx) < VIRT_W) && (int'(vy) < VIRT_H) && (int'(px) < PHYS_W);
    drop  = (in_ch.data.op == OP_WRITE) && !in_range;
    addr  = AW'(int'(py) * PHYS_W + int'(px));
  end

  // two-entry queue
  logic [ENT-1:0] mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push;
  logic           pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && !drop;
  assign pop  = q_pop && (cnt_r != 2'd0);
  assign q_valid = (cnt_r != 2'd0);
  assign {q_op, q_addr, q_rgb} = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= {in_ch.data.op, addr,
                      in_ch.data.blue_on, in_ch.data.green_on, in_ch.data.red_on};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ rtl/core/hqsd_back.sv @@
// ----------------------------------------------------------------------------
// hqsd_back
// Executes queued commands: writes and clears the back buffer, swaps buffers
// and runs the scan sequencer that emits one pin word per tick.
// ----------------------------------------------------------------------------
module hqsd_back #(
  parameter int PANEL_COLUMNS = 32,
  parameter int PANEL_ROWS    = 32,
  parameter int CHAIN_PANELS  = 2,
  parameter int AW            = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [1:0]          q_op,
  input  logic [AW-1:0]       q_addr,
  input  logic [2:0]          q_rgb,
  input  logic [15:0]         display_ticks,
  hqsd_stream_if.source       out_ch
);
  import hqsd_pkg::*;

  localparam int PHYS_W   = PANEL_COLUMNS * CHAIN_PANELS;
  localparam int BUF      = PHYS_W * PANEL_ROWS;
  localparam int QROWS    = PANEL_ROWS / 4;
  localparam int COLS     = PHYS_W * 2;
  localparam int CW       = $clog2(COLS + 1);
  localparam int RW       = (QROWS > 1) ? $clog2(QROWS) : 1;

  localparam logic [1:0] PH_SHIFT = 2'd0;
  localparam logic [1:0] PH_LATCH = 2'd1;
  localparam logic [1:0] PH_SHOW  = 2'd2;

  // back-end states
  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  // two banks; bank valid-by-epoch is not used, clears are swept
  logic [2:0] mem_a [BUF];
  logic [2:0] mem_b [BUF];

  logic [1:0]    st_r, st_nxt;
  logic          front_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [1:0]    ph_r;
  logic [15:0]   dcnt_r;
  logic [AW:0]   clr_r;
  logic          clr_all_r;
  logic          out_v_r;
  out_item_t     out_r;
  logic          rd_up_ok_r, rd_lo_ok_r;
  logic [2:0]    rd_up_a_r, rd_up_b_r, rd_lo_a_r, rd_lo_b_r;
  logic          rd_front_r;

  // scan address for current column
  logic [15:0] pidx, fx, y1, y2;
  logic [AW-1:0] a_up, a_lo;
  logic up_ok, lo_ok;
  always_comb begin
    pidx = 16'(int'(col_r) / PANEL_COLUMNS);
    fx   = 16'((int'(pidx) / 2) * PANEL_COLUMNS + int'(col_r) % PANEL_COLUMNS);
    y1   = pidx[0] ? 16'(row_r) : 16'(int'(row_r) + QROWS);
    y2   = 16'(int'(y1) + 2 * QROWS);
    up_ok = (int'(y1) < PANEL_ROWS) && (int'(fx) < PHYS_W);
    lo_ok = (int'(y2) < PANEL_ROWS) && (int'(fx) < PHYS_W);
    a_up = AW'(int'(y1) * PHYS_W + int'(fx));
    a_lo = AW'(int'(y2) * PHYS_W + int'(fx));
  end

  logic out_free;
  logic is_shift;
  assign out_free = !out_v_r || out_ch.ready;
  assign is_shift = (ph_r != PH_LATCH) && (ph_r != PH_SHOW);

  always_comb begin
    q_pop  = 1'b0;
    st_nxt = st_r;
    case (st_r)
      S_RUN: begin
        if (q_valid) begin
          case (q_op)
            OP_CLEAR: begin q_pop = 1'b1; st_nxt = S_CLEAR; end
            OP_TICK: begin
              if (is_shift) begin
                q_pop = 1'b1; st_nxt = S_READ;
              end else if (out_free) begin
                q_pop = 1'b1;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      S_CLEAR: if (clr_r == (AW+1)'(BUF - 1)) st_nxt = S_RUN;
      S_READ:  if (out_free) st_nxt = S_RUN;
      default: st_nxt = S_RUN;
    endcase
  end

  // memory ports: write port shared by pixel write and clear sweep;
  // the sweep after reset clears both banks
  logic          we_a, we_b;
  logic [AW-1:0] waddr;
  logic [2:0]    wdata;
  always_comb begin
    we_a = 1'b0; we_b = 1'b0;
    waddr = q_addr; wdata = q_rgb;
    if (st_r == S_CLEAR) begin
      waddr = clr_r[AW-1:0]; wdata = 3'd0;
      we_a = front_r || clr_all_r; we_b = !front_r || clr_all_r;
    end else if (q_pop && q_op == OP_WRITE) begin
      we_a = front_r; we_b = !front_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    if (we_b) mem_b[waddr] <= wdata;
    rd_up_a_r <= mem_a[a_up];
    rd_up_b_r <= mem_b[a_up];
    rd_lo_a_r <= mem_a[a_lo];
    rd_lo_b_r <= mem_b[a_lo];
    rd_up_ok_r <= up_ok;
    rd_lo_ok_r <= lo_ok;
    rd_front_r <= front_r;
  end

  logic [15:0] limit;
  logic [15:0] dinc;
  assign limit = (display_ticks == 16'd0) ? 16'd1 : display_ticks;
  assign dinc  = dcnt_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLEAR;
      clr_r     <= '0;
      clr_all_r <= 1'b1;
      front_r   <= 1'b0;
      row_r     <= '0;
      col_r     <= '0;
      ph_r      <= PH_SHIFT;
      dcnt_r    <= '0;
      out_v_r   <= 1'b0;
      out_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      if (st_r == S_CLEAR) begin
        clr_r <= (clr_r == (AW+1)'(BUF - 1)) ? '0 : clr_r + 1'b1;
        if (clr_r == (AW+1)'(BUF - 1)) clr_all_r <= 1'b0;
      end
      if (st_r == S_RUN && q_pop && q_op == OP_SWAP) front_r <= ~front_r;
      // latch / display ticks
      if (st_r == S_RUN && q_pop && q_op == OP_TICK && !is_shift) begin
        out_v_r <= 1'b1;
        out_r.upper_rgb <= 3'd0;
        out_r.lower_rgb <= 3'd0;
        out_r.row_address <= 3'(row_r);
        out_r.shift_clock <= 1'b0;
        if (ph_r == PH_LATCH) begin
          out_r.latch_pulse <= 1'b1;
          out_r.output_enable_n <= 1'b1;
          ph_r <= PH_SHOW;
          dcnt_r <= '0;
        end else begin
          out_r.latch_pulse <= 1'b0;
          out_r.output_enable_n <= 1'b0;
          if (dinc >= limit) begin
            dcnt_r <= '0;
            ph_r <= PH_SHIFT;
            row_r <= (int'(row_r) + 1 >= QROWS) ? '0 : RW'(int'(row_r) + 1);
          end else begin
            dcnt_r <= dinc;
          end
        end
      end
      // shift tick: read data arrives, emit word
      if (st_r == S_READ && out_free) begin
        out_v_r <= 1'b1;
        out_r.upper_rgb <= !rd_up_ok_r ? 3'd0 : (rd_front_r ? rd_up_b_r : rd_up_a_r);
        out_r.lower_rgb <= !rd_lo_ok_r ? 3'd0 : (rd_front_r ? rd_lo_b_r : rd_lo_a_r);
        out_r.row_address <= 3'(row_r);
        out_r.shift_clock <= 1'b1;
        out_r.latch_pulse <= 1'b0;
        out_r.output_enable_n <= 1'b1;
        ph_r <= PH_SHIFT;
        if (int'(col_r) + 1 >= COLS) begin
          col_r <= '0;
          ph_r  <= PH_LATCH;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;
endmodule

@@ rtl/core/hub75_quarter_scan_driver.sv @@
// ----------------------------------------------------------------------------
// hub75_quarter_scan_driver
// Double-buffered 3-bit framebuffer driving a chain of 1/4-scan panels.
// ----------------------------------------------------------------------------
// A scan tick that shifts a column passes the registered framebuffer read,
// then presents the pin word, waiting while the output is stalled; latch
// and display ticks, pixel writes and swaps are executed as they are popped.
// A clear walks the back buffer one pixel a cycle, and the same sweep runs
// after reset over both banks' write port before the first item is
// executed. A two-entry queue lets input be taken while the back end works.
module hub75_quarter_scan_driver #(
  parameter int PANEL_COLUMNS = 32,
  parameter int PANEL_ROWS    = 32,
  parameter int CHAIN_PANELS  = 2,
  parameter int GRID_ACROSS   = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  hqsd_stream_if.sink   in_ch,
  hqsd_stream_if.source out_ch,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);
  import hqsd_pkg::*;

  localparam int AW = $clog2(PANEL_COLUMNS * CHAIN_PANELS * PANEL_ROWS);

  logic [15:0] dticks_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) dticks_r <= 16'(DISPLAY_TICKS_RESET);
    else if (cfg_valid) dticks_r <= cfg_data;
  end

  logic          q_valid, q_pop;
  logic [1:0]    q_op;
  logic [AW-1:0] q_addr;
  logic [2:0]    q_rgb;

  hqsd_front #(
    .PANEL_COLUMNS(PANEL_COLUMNS), .PANEL_ROWS(PANEL_ROWS),
    .CHAIN_PANELS(CHAIN_PANELS), .GRID_ACROSS(GRID_ACROSS), .AW(AW)
  ) u_front (
    .clk, .rst_n, .in_ch,
    .q_valid, .q_pop, .q_op, .q_addr, .q_rgb
  );

  hqsd_back #(
    .PANEL_COLUMNS(PANEL_COLUMNS), .PANEL_ROWS(PANEL_ROWS),
    .CHAIN_PANELS(CHAIN_PANELS), .AW(AW)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_op, .q_addr, .q_rgb,
    .display_ticks(dticks_r), .out_ch
  );
endmodule
